/* sv/btp_pkg.sv */
`default_nettype none

package btp_pkg;

    // History ring geometry (depth must be a power of two)
    localparam int HIST_DEPTH = 8;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // Field widths
    localparam int TIME_W     = 32;
    localparam int IBI_W      = 11;
    localparam int OFFSET_W   = 9;
    localparam int SUM_W      = IBI_W + HIST_AW;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Interval limits and reset values
    localparam logic [IBI_W-1:0] IBI_MIN        = IBI_W'(300);
    localparam logic [IBI_W-1:0] IBI_MAX        = IBI_W'(2000);
    localparam logic [IBI_W-1:0] IBI_PRESET     = IBI_W'(800);
    localparam logic [IBI_W-1:0] PLAYBACK_RESET = IBI_W'(857);
    localparam logic [SUM_W-1:0] SUM_PRESET     = SUM_W'(800 * HIST_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_EN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK_IV = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TRANSIT_OFS = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        CAUSE_PLAYBACK = 2'd0,
        CAUSE_DUE      = 2'd1,
        CAUSE_OFFSET   = 2'd2,
        CAUSE_EARLY    = 2'd3
    } cause_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              peak_seen;
        logic [TIME_W-1:0] peak_time_ms;
    } item_t;

    typedef struct packed {
        logic [IBI_W-1:0] interval;
        cause_t           cause;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } step_out_t;

endpackage

`default_nettype wire

/* sv/beat_trigger_predictor.sv */
`default_nettype none

// Beat trigger scheduler. Each transfer on the s_ channel is one scheduler tick
// and yields zero, one or two beats on the m_ channel, the final one of a tick
// flagged by m_last_of_item. A tick is captured in an input register and worked
// out combinationally into a two-entry result buffer, so one tick per cycle is
// taken while each tick yields at most one beat and m_ready stays high; a tick
// with two beats holds the input while the result buffer drains. Configuration
// writes on cfg_* are always ready and take effect on the next cycle; write them
// only while no tick is in flight. Times wrap at 2^32.
module beat_trigger_predictor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [btp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [btp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // tick input
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [btp_pkg::TIME_W-1:0]      s_now_ms,
    input  wire logic                            s_peak_seen,
    input  wire logic [btp_pkg::TIME_W-1:0]      s_peak_time_ms,
    // beat output
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [btp_pkg::IBI_W-1:0]            m_beat_interval_ms,
    output logic [1:0]                           m_beat_cause,
    output logic                                 m_last_of_item
);

    btp_pkg::cfg_wr_t     cfg_wr;
    btp_pkg::item_t       in_reg;
    logic                 in_valid_reg, in_valid_next;
    btp_pkg::step_out_t   step_out;
    btp_pkg::result_t     q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic                 out_free, fire, pop;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // Handshake: the held tick moves once the result buffer can take its beats
    assign pop      = m_valid && m_ready;
    assign out_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || fire;

    btp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .step_fire (fire),
        .item      (in_reg),
        .step_out  (step_out)
    );

    // Capture the tick on transfer
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.now_ms       <= s_now_ms;
            in_reg.peak_seen    <= s_peak_seen;
            in_reg.peak_time_ms <= s_peak_time_ms;
        end
    end

    // Result buffer: load a tick's beats, or advance by one on transfer
    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (fire) begin
            q0_next  = step_out.r0;
            q1_next  = step_out.r1;
            cnt_next = step_out.count;
        end else if (pop) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_valid            = cnt_reg != 2'd0;
    assign m_beat_interval_ms = q0_reg.interval;
    assign m_beat_cause       = q0_reg.cause;
    assign m_last_of_item     = q0_reg.last;

    // The buffer never holds more than one tick's beats
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer overfilled");

    // A moved tick replaces the buffer with exactly its beats
    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> cnt_reg == $past(step_out.count))
        else $error("result buffer lost or repeated a beat");

    // The head beat of a two-beat buffer is never the last of its tick
    a_head_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !q0_reg.last && q1_reg.last)
        else $error("last flag misplaced");

endmodule

`default_nettype wire

/* sv/btp_core.sv */
`default_nettype none

module btp_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire btp_pkg::cfg_wr_t     cfg_wr,
    input  wire logic                 step_fire,
    input  wire btp_pkg::item_t       item,
    output btp_pkg::step_out_t        step_out
);

    // Configuration registers
    logic                          run_en_reg;
    logic                          pb_en_reg;
    logic [btp_pkg::IBI_W-1:0]     pb_iv_reg;
    logic [btp_pkg::OFFSET_W-1:0]  offset_reg;

    // Tick state
    logic [btp_pkg::IBI_W-1:0]     ring_reg  [btp_pkg::HIST_DEPTH];
    logic [btp_pkg::IBI_W-1:0]     ring_next [btp_pkg::HIST_DEPTH];
    logic [btp_pkg::HIST_AW-1:0]   pos_reg, pos_next;
    logic [btp_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [btp_pkg::TIME_W-1:0]    prev_time_reg, prev_time_next;
    logic                          prev_valid_reg, prev_valid_next;
    logic                          pending_reg, pending_next;
    logic [btp_pkg::TIME_W-1:0]    pred_reg, pred_next;
    logic [btp_pkg::TIME_W-1:0]    pbref_reg, pbref_next;
    logic                          running_reg, running_next;

    // Step datapath
    logic [btp_pkg::IBI_W-1:0]     avg_old, avg_rec, avg_new, ibi;
    logic [btp_pkg::SUM_W-1:0]     sum_rec;
    logic [btp_pkg::TIME_W-1:0]    diff, ref_time, elapsed, since_pred, until_pred;
    logic [btp_pkg::TIME_W-1:0]    pred_new;
    logic                          pb_hit, due, early, offset_hit;
    logic                          e_pb, e_due, e_peak;
    btp_pkg::cause_t               peak_cause;

    // Take configuration writes; unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_en_reg <= 1'b0;
            pb_en_reg  <= 1'b0;
            pb_iv_reg  <= btp_pkg::PLAYBACK_RESET;
            offset_reg <= '0;
        end else if (cfg_wr.valid) begin
            case (cfg_wr.index)
                btp_pkg::REG_RUN_ENABLE:  run_en_reg <= cfg_wr.data[0];
                btp_pkg::REG_PLAYBACK_EN: pb_en_reg  <= cfg_wr.data[0];
                btp_pkg::REG_PLAYBACK_IV: pb_iv_reg  <= cfg_wr.data[btp_pkg::IBI_W-1:0];
                btp_pkg::REG_TRANSIT_OFS: offset_reg <= cfg_wr.data[btp_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the new inter-beat interval, negative differences go to the minimum
    assign diff = item.peak_time_ms - prev_time_reg;
    always_comb begin
        if (diff[btp_pkg::TIME_W-1] || diff < btp_pkg::TIME_W'(btp_pkg::IBI_MIN)) begin
            ibi = btp_pkg::IBI_MIN;
        end else if (diff > btp_pkg::TIME_W'(btp_pkg::IBI_MAX)) begin
            ibi = btp_pkg::IBI_MAX;
        end else begin
            ibi = diff[btp_pkg::IBI_W-1:0];
        end
    end

    // Running sum replaces the oldest entry; average is sum over depth
    assign avg_old = sum_reg[btp_pkg::SUM_W-1:btp_pkg::HIST_AW];
    assign sum_rec = sum_reg - btp_pkg::SUM_W'(ring_reg[pos_reg]) + btp_pkg::SUM_W'(ibi);
    assign avg_rec = sum_rec[btp_pkg::SUM_W-1:btp_pkg::HIST_AW];
    assign avg_new = prev_valid_reg ? avg_rec : avg_old;

    // Playback timing
    assign ref_time = running_reg ? pbref_reg : item.now_ms;
    assign elapsed  = item.now_ms - ref_time;
    assign pb_hit   = elapsed >= btp_pkg::TIME_W'(pb_iv_reg);

    // Prediction tests
    assign since_pred = item.now_ms - pred_reg;
    assign until_pred = pred_reg - item.peak_time_ms;
    assign due        = pending_reg && !since_pred[btp_pkg::TIME_W-1];
    assign early      = pending_reg && !due && (until_pred != '0)
                        && !until_pred[btp_pkg::TIME_W-1];
    assign offset_hit = avg_new <= btp_pkg::IBI_W'(offset_reg);
    assign pred_new   = item.peak_time_ms
                        + btp_pkg::TIME_W'(avg_new - btp_pkg::IBI_W'(offset_reg));
    assign peak_cause = offset_hit ? btp_pkg::CAUSE_OFFSET : btp_pkg::CAUSE_EARLY;

    // Beats produced by this tick
    assign e_pb   = run_en_reg && pb_en_reg && pb_hit;
    assign e_due  = run_en_reg && !pb_en_reg && due;
    assign e_peak = run_en_reg && !pb_en_reg && item.peak_seen && (offset_hit || early);

    always_comb begin
        step_out = '0;
        if (e_pb) begin
            step_out.count = 2'd1;
        end else begin
            step_out.count = {1'b0, e_due} + {1'b0, e_peak};
        end
        if (e_pb) begin
            step_out.r0.interval = pb_iv_reg;
            step_out.r0.cause    = btp_pkg::CAUSE_PLAYBACK;
        end else if (e_due) begin
            step_out.r0.interval = avg_old;
            step_out.r0.cause    = btp_pkg::CAUSE_DUE;
        end else begin
            step_out.r0.interval = avg_new;
            step_out.r0.cause    = peak_cause;
        end
        step_out.r0.last     = step_out.count == 2'd1;
        step_out.r1.interval = avg_new;
        step_out.r1.cause    = peak_cause;
        step_out.r1.last     = 1'b1;
    end

    // Next state for one tick
    always_comb begin
        ring_next       = ring_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        prev_time_next  = prev_time_reg;
        prev_valid_next = prev_valid_reg;
        pending_next    = pending_reg;
        pred_next       = pred_reg;
        pbref_next      = pbref_reg;
        running_next    = running_reg;
        if (step_fire) begin
            if (!run_en_reg) begin
                pending_next = 1'b0;
                running_next = 1'b0;
            end else begin
                running_next = 1'b1;
                pbref_next   = (pb_en_reg && pb_hit) ? item.now_ms : ref_time;
                if (!pb_en_reg) begin
                    if (due) begin
                        pending_next = 1'b0;
                    end
                    if (item.peak_seen) begin
                        if (prev_valid_reg) begin
                            ring_next[pos_reg] = ibi;
                            pos_next           = pos_reg + btp_pkg::HIST_AW'(1);
                            sum_next           = sum_rec;
                        end
                        prev_time_next  = item.peak_time_ms;
                        prev_valid_next = 1'b1;
                        if (offset_hit) begin
                            pending_next = 1'b0;
                        end else begin
                            pending_next = 1'b1;
                            pred_next    = pred_new;
                        end
                    end
                end
            end
        end
        // Stopping the run drops any pending prediction
        if (cfg_wr.valid && cfg_wr.index == btp_pkg::REG_RUN_ENABLE && !cfg_wr.data[0]) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < btp_pkg::HIST_DEPTH; k++) begin
                ring_reg[k] <= btp_pkg::IBI_PRESET;
            end
            pos_reg        <= '0;
            sum_reg        <= btp_pkg::SUM_PRESET;
            prev_time_reg  <= '0;
            prev_valid_reg <= 1'b0;
            pending_reg    <= 1'b0;
            pred_reg       <= '0;
            pbref_reg      <= '0;
            running_reg    <= 1'b0;
        end else begin
            ring_reg       <= ring_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            prev_time_reg  <= prev_time_next;
            prev_valid_reg <= prev_valid_next;
            pending_reg    <= pending_next;
            pred_reg       <= pred_next;
            pbref_reg      <= pbref_next;
            running_reg    <= running_next;
        end
    end

    // The average stays inside the clamp range
    a_avg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        avg_old >= btp_pkg::IBI_MIN && avg_old <= btp_pkg::IBI_MAX)
        else $error("average interval out of range");

    // A stopped tick leaves no prediction pending
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && !run_en_reg |=> !pending_reg && !running_reg)
        else $error("stopped tick kept prediction");

    // A live running peak always leaves a valid previous peak
    a_peak_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && run_en_reg && !pb_en_reg && item.peak_seen |=> prev_valid_reg)
        else $error("peak not recorded");

    // Two beats in one tick start with the due prediction
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        step_out.count == 2'd2 |-> step_out.r0.cause == btp_pkg::CAUSE_DUE
                                   && !step_out.r0.last)
        else $error("bad beat pair order");

endmodule

`default_nettype wire
